/* src/vsf_pkg.sv */
// shared types, codes and the stroke font table of the vector stroke font generator
`timescale 1ns / 1ps
`default_nettype none

package vsf_pkg;

    localparam int MAG_W = 18;
    localparam logic [16:0] PEN_MAX = 17'h1FFFF;

    localparam logic [1:0] CFG_GLYPH_SIZE = 2'd0;
    localparam logic [1:0] CFG_MAX_WIDTH  = 2'd1;
    localparam logic [1:0] CFG_MEASURE    = 2'd2;

    localparam logic [1:0] KIND_LINE  = 2'd0;
    localparam logic [1:0] KIND_POINT = 2'd1;
    localparam logic [1:0] KIND_NONE  = 2'd2;

    localparam logic [7:0] CH_TAB = 8'd9;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CALC,
        ST_DIV,
        ST_EMIT
    } t_state;

    typedef enum logic [1:0] {
        E_REPORT,
        E_DOTS,
        E_GLYPH
    } t_emit;

    typedef enum logic [1:0] {
        SG_ZERO,
        SG_PLUS,
        SG_MINUS
    } t_sgn;

    typedef enum logic [2:0] {
        W_Q1,
        W_Q2,
        W_Q4,
        W_TAB,
        W_UNK
    } t_wclass;

    typedef struct packed {
        logic [7:0]         ch;
        logic signed [15:0] start_x;
        logic signed [15:0] start_y;
        logic               first_char;
        logic               end_of_string;
    } t_in;

    typedef struct packed {
        logic signed [15:0] x_from;
        logic signed [15:0] y_from;
        logic signed [15:0] x_to;
        logic signed [15:0] y_to;
        logic [1:0]         kind;
        logic [15:0]        text_width;
        logic               last;
    } t_out;

    // one coordinate: base + k*s1 + r*qr + h*(s1/2)
    typedef struct packed {
        logic [2:0] k;
        t_sgn       r;
        t_sgn       h;
    } t_cd;

    typedef struct packed {
        t_cd  x0;
        t_cd  y0;
        t_cd  x1;
        t_cd  y1;
        logic pt;
    } t_sd;

    typedef struct packed {
        logic [4:0]      n;
        t_sd [15:0]      s;
    } t_glyph;

    function automatic t_cd cd(input logic [2:0] k, input t_sgn r, input t_sgn h);
        t_cd v;
        v.k = k;
        v.r = r;
        v.h = h;
        return v;
    endfunction

    function automatic t_cd pc(input logic [2:0] k);
        return cd(k, SG_ZERO, SG_ZERO);
    endfunction

    function automatic void add_seg(inout t_glyph g, input t_cd x0, input t_cd y0,
                                    input t_cd x1, input t_cd y1, input logic p);
        if (g.n < 5'd16) begin
            g.s[g.n[3:0]] = {x0, y0, x1, y1, p};
            g.n = g.n + 5'd1;
        end
    endfunction

    function automatic void ln(inout t_glyph g, input logic [2:0] x0, input logic [2:0] y0,
                               input logic [2:0] x1, input logic [2:0] y1);
        add_seg(g, pc(x0), pc(y0), pc(x1), pc(y1), 1'b0);
    endfunction

    function automatic void pt(inout t_glyph g, input logic [2:0] x, input logic [2:0] y);
        add_seg(g, pc(x), pc(y), pc(x), pc(y), 1'b1);
    endfunction

    // quarter arc as two chords through the 3/4 knee
    function automatic void arc(inout t_glyph g, input logic [2:0] kx, input logic [2:0] ky,
                                input logic right, input logic lower);
        t_sgn       rx;
        t_sgn       ry;
        logic [2:0] ex;
        logic [2:0] ey;
        rx = right ? SG_PLUS : SG_MINUS;
        ry = lower ? SG_PLUS : SG_MINUS;
        ex = right ? 3'(kx + 3'd1) : 3'(kx - 3'd1);
        ey = lower ? 3'(ky + 3'd1) : 3'(ky - 3'd1);
        add_seg(g, pc(ex), pc(ky), cd(kx, rx, SG_ZERO), cd(ky, ry, SG_ZERO), 1'b0);
        add_seg(g, cd(kx, rx, SG_ZERO), cd(ky, ry, SG_ZERO), pc(kx), pc(ey), 1'b0);
    endfunction

    function automatic void a_up(inout t_glyph g, input logic [2:0] kx, input logic [2:0] ky);
        arc(g, kx, ky, 1'b0, 1'b0);
        arc(g, kx, ky, 1'b1, 1'b0);
    endfunction

    function automatic void a_lo(inout t_glyph g, input logic [2:0] kx, input logic [2:0] ky);
        arc(g, kx, ky, 1'b0, 1'b1);
        arc(g, kx, ky, 1'b1, 1'b1);
    endfunction

    function automatic t_wclass f_wclass(input logic [7:0] c);
        t_wclass w;
        case (c)
            "l", "t", "f", "i", "j", "k", "-", ".", " ", "(", ")": w = W_Q1;
            "?", "/", "%", "a", "b", "c", "d", "e", "g", "h", "n", "o", "p", "q", "r",
            "s", "u", "v", "x", "y", "z", "A", "B", "C", "D", "E", "F", "G", "H", "I",
            "J", "K", "L", "N", "O", "P", "Q", "R", "S", "T", "U", "V", "X", "Y", "Z",
            "0", "1", "2", "3", "4", "5", "6", "7", "8", "9": w = W_Q2;
            "m", "w", "M", "W": w = W_Q4;
            CH_TAB: w = W_TAB;
            default: w = W_UNK;
        endcase
        return w;
    endfunction

    function automatic t_glyph f_glyph(input logic [7:0] c);
        t_glyph g;
        g = '0;
        case (c)
            "a", "b", "d", "g", "o", "p", "q", "6", "8": begin
                a_up(g, 3'd1, 3'd3);
                a_lo(g, 3'd1, 3'd3);
            end
            default: begin
                case (c)
                    "c", "e", "h", "m", "n", "r", "s": arc(g, 3'd1, 3'd3, 1'b0, 1'b0);
                    default: ;
                endcase
                case (c)
                    "e", "h", "m", "n", "r", "B", "S", "3", "5": arc(g, 3'd1, 3'd3, 1'b1, 1'b0);
                    default: ;
                endcase
                case (c)
                    "c", "e", "t", "u", "y", "C", "G", "J", "O", "Q", "S", "U", "l", "0", "3",
                    "5": arc(g, 3'd1, 3'd3, 1'b0, 1'b1);
                    default: ;
                endcase
                case (c)
                    "s", "u", "y", "B", "C", "D", "G", "J", "O", "Q", "S", "U", "0", "3",
                    "5": arc(g, 3'd1, 3'd3, 1'b1, 1'b1);
                    default: ;
                endcase
                case (c)
                    "B", "D", "E", "F", "H", "K", "L", "M", "N", "P", "R": ln(g, 0, 0, 0, 4);
                    default: ;
                endcase
            end
        endcase
        case (c)
            "a": ln(g, 2, 2, 2, 4);
            "b": ln(g, 0, 0, 0, 4);
            "c": begin ln(g, 1, 2, 2, 2); ln(g, 1, 4, 2, 4); end
            "d": ln(g, 2, 0, 2, 4);
            "e": begin ln(g, 0, 3, 2, 3); ln(g, 1, 4, 2, 4); end
            "f": begin arc(g, 1, 1, 1'b0, 1'b0); ln(g, 0, 1, 0, 4); ln(g, 0, 2, 1, 2); end
            "g": begin ln(g, 2, 2, 2, 5); a_lo(g, 1, 5); end
            "h": begin ln(g, 0, 0, 0, 4); ln(g, 2, 3, 2, 4); end
            "i": begin pt(g, 0, 1); ln(g, 0, 2, 0, 4); end
            "j": begin ln(g, 1, 2, 1, 5); arc(g, 0, 5, 1'b1, 1'b1); pt(g, 1, 1); end
            "k": begin ln(g, 0, 0, 0, 4); ln(g, 0, 3, 1, 2); ln(g, 0, 3, 1, 4); end
            "l": ln(g, 0, 0, 0, 3);
            "m": begin
                ln(g, 0, 2, 0, 4); ln(g, 2, 3, 2, 4); ln(g, 4, 3, 4, 4); a_up(g, 3, 3);
            end
            "n": begin ln(g, 0, 2, 0, 4); ln(g, 2, 3, 2, 4); end
            "p": ln(g, 0, 2, 0, 6);
            "q": ln(g, 2, 2, 2, 6);
            "r": ln(g, 0, 2, 0, 4);
            "s": begin ln(g, 0, 3, 2, 3); ln(g, 1, 2, 2, 2); ln(g, 0, 4, 1, 4); end
            "t": begin ln(g, 0, 1, 0, 3); ln(g, 0, 2, 1, 2); end
            "u": begin ln(g, 0, 2, 0, 3); ln(g, 2, 2, 2, 4); end
            "v": begin ln(g, 0, 2, 1, 4); ln(g, 1, 4, 2, 2); end
            "w": begin
                ln(g, 0, 2, 1, 4); ln(g, 1, 4, 2, 3); ln(g, 2, 3, 3, 4); ln(g, 3, 4, 4, 2);
            end
            "x": begin ln(g, 0, 2, 2, 4); ln(g, 0, 4, 2, 2); end
            "y": begin ln(g, 0, 2, 0, 3); ln(g, 2, 2, 2, 5); a_lo(g, 1, 5); end
            "z": begin ln(g, 0, 2, 2, 2); ln(g, 2, 2, 0, 4); ln(g, 0, 4, 2, 4); end
            "A": begin
                ln(g, 0, 4, 1, 0); ln(g, 1, 0, 2, 4);
                add_seg(g, cd(0, SG_ZERO, SG_PLUS), pc(2), cd(2, SG_ZERO, SG_MINUS), pc(2),
                        1'b0);
            end
            "B": begin
                arc(g, 1, 1, 1'b1, 1'b0); arc(g, 1, 1, 1'b1, 1'b1);
                ln(g, 0, 0, 1, 0); ln(g, 0, 2, 1, 2); ln(g, 0, 4, 1, 4);
            end
            "C": begin a_up(g, 1, 1); ln(g, 0, 1, 0, 3); end
            "D": begin
                ln(g, 0, 0, 1, 0); ln(g, 0, 4, 1, 4); arc(g, 1, 1, 1'b1, 1'b0);
                ln(g, 2, 1, 2, 3);
            end
            "E": begin ln(g, 0, 0, 2, 0); ln(g, 0, 2, 1, 2); ln(g, 0, 4, 2, 4); end
            "F": begin ln(g, 0, 0, 2, 0); ln(g, 0, 2, 1, 2); end
            "G": begin
                a_up(g, 1, 1); ln(g, 0, 1, 0, 3); ln(g, 1, 2, 2, 2); ln(g, 2, 2, 2, 3);
            end
            "H": begin ln(g, 0, 2, 2, 2); ln(g, 2, 0, 2, 4); end
            "I": begin ln(g, 0, 0, 2, 0); ln(g, 1, 0, 1, 4); ln(g, 0, 4, 2, 4); end
            "J": ln(g, 2, 0, 2, 3);
            "K": begin ln(g, 2, 0, 0, 2); ln(g, 0, 2, 2, 4); end
            "L": ln(g, 0, 4, 2, 4);
            "M": begin
                add_seg(g, pc(0), pc(0), cd(1, SG_ZERO, SG_PLUS), pc(2), 1'b0);
                add_seg(g, cd(1, SG_ZERO, SG_PLUS), pc(2), pc(3), pc(0), 1'b0);
                ln(g, 3, 0, 3, 4);
            end
            "N": begin ln(g, 0, 0, 2, 4); ln(g, 2, 4, 2, 0); end
            "Q": begin
                ln(g, 1, 3, 2, 4); a_up(g, 1, 1); ln(g, 0, 1, 0, 3); ln(g, 2, 1, 2, 3);
            end
            "0", "O": begin a_up(g, 1, 1); ln(g, 0, 1, 0, 3); ln(g, 2, 1, 2, 3); end
            "R": begin
                ln(g, 1, 2, 2, 4); arc(g, 1, 1, 1'b1, 1'b0); arc(g, 1, 1, 1'b1, 1'b1);
                ln(g, 0, 0, 1, 0); ln(g, 0, 2, 1, 2);
            end
            "P": begin
                arc(g, 1, 1, 1'b1, 1'b0); arc(g, 1, 1, 1'b1, 1'b1);
                ln(g, 0, 0, 1, 0); ln(g, 0, 2, 1, 2);
            end
            "S": begin
                arc(g, 1, 1, 1'b0, 1'b0); arc(g, 1, 1, 1'b0, 1'b1); arc(g, 1, 1, 1'b1, 1'b0);
            end
            "T": begin ln(g, 0, 0, 2, 0); ln(g, 1, 0, 1, 4); end
            "U": begin ln(g, 0, 0, 0, 3); ln(g, 2, 0, 2, 3); end
            "V": begin ln(g, 0, 0, 1, 4); ln(g, 1, 4, 2, 0); end
            "W": begin
                ln(g, 0, 0, 1, 4); ln(g, 1, 4, 2, 2); ln(g, 2, 2, 3, 4); ln(g, 3, 4, 4, 0);
            end
            "X": begin ln(g, 0, 0, 2, 4); ln(g, 2, 0, 0, 4); end
            "Y": begin ln(g, 0, 0, 1, 2); ln(g, 2, 0, 1, 2); ln(g, 1, 2, 1, 4); end
            "Z": begin ln(g, 0, 0, 2, 0); ln(g, 2, 0, 0, 4); ln(g, 0, 4, 2, 4); end
            "1": begin ln(g, 0, 1, 1, 0); ln(g, 1, 0, 1, 4); ln(g, 0, 4, 2, 4); end
            "2": begin a_up(g, 1, 1); ln(g, 2, 1, 0, 4); ln(g, 0, 4, 2, 4); end
            "3": begin a_up(g, 1, 1); arc(g, 1, 1, 1'b1, 1'b1); end
            "4": begin ln(g, 1, 4, 1, 0); ln(g, 1, 0, 0, 2); ln(g, 0, 2, 2, 2); end
            "5": begin ln(g, 2, 0, 0, 0); ln(g, 0, 0, 0, 2); ln(g, 0, 2, 1, 2); end
            "6": begin a_up(g, 1, 1); ln(g, 0, 1, 0, 3); end
            "7": begin ln(g, 0, 0, 2, 0); ln(g, 2, 0, 1, 4); end
            "9": begin ln(g, 2, 0, 2, 4); a_up(g, 1, 1); a_lo(g, 1, 1); end
            "8": begin a_up(g, 1, 1); a_lo(g, 1, 1); end
            "-": ln(g, 0, 2, 1, 2);
            ".": pt(g, 0, 4);
            "(": begin arc(g, 1, 1, 1'b0, 1'b0); arc(g, 1, 3, 1'b0, 1'b1); ln(g, 0, 1, 0, 3); end
            ")": begin arc(g, 0, 1, 1'b1, 1'b0); arc(g, 0, 3, 1'b1, 1'b1); ln(g, 1, 1, 1, 3); end
            "%": begin pt(g, 0, 0); pt(g, 2, 4); ln(g, 0, 4, 2, 0); end
            "/": ln(g, 0, 4, 2, 0);
            "?": begin
                a_up(g, 1, 1); ln(g, 2, 1, 1, 2); ln(g, 1, 2, 1, 3); pt(g, 1, 4);
            end
            default: ;
        endcase
        // unknown codes draw an underscore
        if (f_wclass(c) == W_UNK) begin
            ln(g, 0, 4, 2, 4);
        end
        return g;
    endfunction

endpackage

`default_nettype wire

/* src/vsf_coord_unit.sv */
// stroke endpoint unit: turns a stroke descriptor into four pixel coordinates
`timescale 1ns / 1ps
`default_nettype none

module vsf_coord_unit
    import vsf_pkg::*;
(
    input  wire logic [15:0] i_base_x,
    input  wire logic [15:0] i_base_y,
    input  wire logic [5:0]  i_q1,
    input  wire t_sd         i_sd,
    output logic [15:0]      o_x0,
    output logic [15:0]      o_y0,
    output logic [15:0]      o_x1,
    output logic [15:0]      o_y1
);

    logic [7:0] w_qr;
    logic [5:0] w_h;

    function automatic logic [15:0] coord(input logic [15:0] base, input t_cd d,
                                          input logic [5:0] q1, input logic [7:0] qr,
                                          input logic [5:0] h);
        logic [15:0] v;
        v = base + 16'(d.k * q1);
        unique case (d.r)
            SG_PLUS:  v = v + 16'(qr);
            SG_MINUS: v = v - 16'(qr);
            default:  ;
        endcase
        unique case (d.h)
            SG_PLUS:  v = v + 16'(h);
            SG_MINUS: v = v - 16'(h);
            default:  ;
        endcase
        return v;
    endfunction

    // knee at 3/4 of the radius
    assign w_qr = 8'((10'(i_q1) * 10'd3) >> 2);
    assign w_h  = i_q1 >> 1;

    assign o_x0 = coord(i_base_x, i_sd.x0, i_q1, w_qr, w_h);
    assign o_y0 = coord(i_base_y, i_sd.y0, i_q1, w_qr, w_h);
    assign o_x1 = coord(i_base_x, i_sd.x1, i_q1, w_qr, w_h);
    assign o_y1 = coord(i_base_y, i_sd.y1, i_q1, w_qr, w_h);

endmodule

`default_nettype wire

/* src/vsf_tab_div.sv */
// two-stage reciprocal unit giving the remainder of the pen position by the tab width
`timescale 1ns / 1ps
`default_nettype none

module vsf_tab_div
    import vsf_pkg::*;
#(
    parameter int TAB_WIDTH = 64
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_start,
    input  wire logic [MAG_W-1:0]               i_num,
    output logic                                o_done,
    output logic [$clog2(TAB_WIDTH+1)-1:0]      o_rem
);

    localparam int RW = $clog2(TAB_WIDTH + 1);
    localparam int LW = $clog2(TAB_WIDTH);
    localparam int SH = MAG_W + LW;
    localparam int PW = SH + MAG_W;
    // rounded-up reciprocal, exact quotient for every MAG_W-bit numerator
    localparam logic [MAG_W:0] MUL = (MAG_W + 1)'(((longint'(1) << SH)
                                     + longint'(TAB_WIDTH) - longint'(1)) / longint'(TAB_WIDTH));

    logic             r_s1;
    logic             r_s2;
    logic             r_done;
    logic [MAG_W-1:0] r_num;
    logic [MAG_W-1:0] r_q;
    logic [RW-1:0]    r_rem;
    logic [PW-1:0]    w_prod;
    logic [MAG_W-1:0] w_quo;
    logic [MAG_W-1:0] w_qt;
    logic [MAG_W-1:0] w_diff;

    assign w_prod = PW'(r_num) * PW'(MUL);
    assign w_quo  = w_prod[PW-1:SH];
    assign w_qt   = r_q * MAG_W'(TAB_WIDTH);
    assign w_diff = r_num - w_qt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1   <= 1'b0;
            r_s2   <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_s1   <= i_start;
            r_s2   <= r_s1;
            r_done <= r_s2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
        end
        if (r_s1) begin
            r_q <= w_quo;
        end
        if (r_s2) begin
            r_rem <= RW'(w_diff);
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

`default_nettype wire

/* src/vector_stroke_font_generator.sv */
// top level: character sequencer, pen arithmetic and stroke output register
//
//  channel   | handshake                     | payload
//  ----------+-------------------------------+---------------------------
//  config    | i_cfg_we                      | i_cfg_idx, i_cfg_data
//  input     | i_in_valid / o_in_ready       | i_in  (t_in)
//  output    | o_out_valid / i_out_ready     | o_out (t_out)
//
// a character is accepted in ST_IDLE, its pen arithmetic is done in ST_CALC and its 1 to 16
// results are sent from ST_EMIT, one stroke a cycle from the stroke unit while not stalled
// a tab waits in ST_DIV for the reciprocal unit that finds the remainder by the tab width
// o_in_ready is high only while the sequencer is idle; output stalls hold the sequencer
// synchronous active-low reset restores the register defaults and clears pen and origin
`timescale 1ns / 1ps
`default_nettype none

module vector_stroke_font_generator
    import vsf_pkg::*;
#(
    parameter int TAB_WIDTH = 64
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_idx,
    input  wire logic [15:0] i_cfg_data,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire t_in         i_in,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output t_out             o_out
);

    localparam int REM_W = $clog2(TAB_WIDTH + 1);

    t_state r_state, n_state;
    logic [5:0]         r_gs;
    logic [15:0]        r_maxw;
    logic               r_meas;
    logic [7:0]         r_ch, n_ch;
    logic signed [15:0] r_origin_x, n_origin_x;
    logic signed [15:0] r_origin_y, n_origin_y;
    logic [16:0]        r_pen, n_pen;
    logic               r_clipped, n_clipped;
    logic [15:0]        r_gx, n_gx;
    logic [15:0]        r_dot_x, n_dot_x;
    t_emit              r_mode, n_mode;
    logic [4:0]         r_cnt, n_cnt;
    logic [3:0]         r_idx, n_idx;
    logic               r_out_valid, n_out_valid;
    t_out               r_out, n_out;

    logic               w_draw;
    logic signed [19:0] w_q1, w_gap, w_wid, w_extra, w_shift, w_step;
    logic signed [19:0] w_a, w_mag, w_lim, w_pen_s, w_sum, w_dots, w_tab, w_rem;
    logic               w_clip, w_free, w_last, w_div_start, w_div_done;
    logic [REM_W-1:0]   w_div_rem;
    t_wclass            w_wc;
    t_glyph             w_glyph;
    t_sd                w_sd;
    logic [15:0]        w_base_x;
    logic [15:0]        w_x0, w_y0, w_x1, w_y1;

    function automatic logic [16:0] clamp_pen(input logic signed [19:0] v);
        logic [16:0] r;
        if (v < 0) begin
            r = '0;
        end else if (v > $signed(20'(PEN_MAX))) begin
            r = PEN_MAX;
        end else begin
            r = v[16:0];
        end
        return r;
    endfunction

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gs   <= 6'd2;
            r_maxw <= 16'hFFFF;
            r_meas <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_GLYPH_SIZE: r_gs   <= i_cfg_data[5:0];
                CFG_MAX_WIDTH:  r_maxw <= i_cfg_data;
                CFG_MEASURE:    r_meas <= i_cfg_data[0];
                default:        ;
            endcase
        end
    end

    // pen arithmetic
    always_comb begin
        w_draw  = !r_meas;
        w_wc    = f_wclass(r_ch);
        w_glyph = f_glyph(r_ch);
        w_q1    = 20'(r_gs);
        w_gap   = (r_gs == '0) ? 20'sd1 : w_q1;
        w_pen_s = 20'(r_pen);
        w_a     = 20'(r_origin_x) + w_pen_s;
        w_lim   = 20'(r_maxw) - w_q1 * 20'sd7;
        w_clip  = !r_clipped && (r_maxw != 16'hFFFF) && (w_pen_s > w_lim);
        unique case (w_wc)
            W_Q1:    w_wid = w_q1;
            W_Q4:    w_wid = w_q1 <<< 2;
            default: w_wid = w_q1 <<< 1;
        endcase
        w_extra = '0;
        w_shift = '0;
        if (w_draw) begin
            if ((r_ch >= "0" && r_ch <= "9") || r_ch == "Q") begin
                w_extra = 20'sd3;
            end
            if (r_ch == "i" || r_ch == ".") begin
                w_shift = w_q1 - 20'sd1;
            end else if (r_ch == "M") begin
                w_shift = w_q1;
            end
        end
        w_sum  = w_pen_s + w_wid + w_gap + w_extra - w_shift;
        w_step = w_draw ? (20'sd1 + w_gap) : (w_q1 + w_gap);
        w_dots = w_pen_s + w_step + (w_step <<< 1);
        // tab: truncating division, done on the magnitude
        w_mag  = w_a[19] ? -w_a : w_a;
        w_rem  = 20'(w_div_rem);
        w_tab  = (w_a[19] ? (w_a + w_rem) : (w_a - w_rem)) + 20'sd0 + 20'(TAB_WIDTH)
                 + w_gap - 20'(r_origin_x);
    end

    assign w_div_start = (r_state == ST_CALC) && !r_clipped && !w_clip && (w_wc == W_TAB);

    vsf_tab_div #(
        .TAB_WIDTH (TAB_WIDTH)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_mag[MAG_W-1:0]),
        .o_done  (w_div_done),
        .o_rem   (w_div_rem)
    );

    // shared stroke unit: glyph strokes, or the clip dots
    always_comb begin
        if (r_mode == E_DOTS) begin
            w_sd     = {pc(3'd0), pc(3'd4), pc(3'd0), pc(3'd4), 1'b1};
            w_base_x = r_dot_x;
        end else begin
            w_sd     = w_glyph.s[r_idx];
            w_base_x = r_gx;
        end
    end

    vsf_coord_unit u_coord (
        .i_base_x (w_base_x),
        .i_base_y (r_origin_y),
        .i_q1     (r_gs),
        .i_sd     (w_sd),
        .o_x0     (w_x0),
        .o_y0     (w_y0),
        .o_x1     (w_x1),
        .o_y1     (w_y1)
    );

    assign w_free = !r_out_valid || i_out_ready;
    assign w_last = (5'(r_idx) + 5'd1) == r_cnt;

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_ch        = r_ch;
        n_origin_x  = r_origin_x;
        n_origin_y  = r_origin_y;
        n_pen       = r_pen;
        n_clipped   = r_clipped;
        n_gx        = r_gx;
        n_dot_x     = r_dot_x;
        n_mode      = r_mode;
        n_cnt       = r_cnt;
        n_idx       = r_idx;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_ch = i_in.ch;
                    if (i_in.first_char) begin
                        n_origin_x = i_in.start_x;
                        n_origin_y = i_in.start_y;
                        n_pen      = '0;
                        n_clipped  = 1'b0;
                    end
                    n_state = ST_CALC;
                end
            end
            ST_CALC: begin
                n_gx    = 16'(r_origin_x) + r_pen[15:0];
                n_dot_x = 16'(r_origin_x) + r_pen[15:0];
                n_idx   = '0;
                n_mode  = E_REPORT;
                n_cnt   = 5'd1;
                n_state = ST_EMIT;
                if (r_clipped) begin
                    n_mode = E_REPORT;
                end else if (w_clip) begin
                    n_clipped = 1'b1;
                    n_pen     = clamp_pen(w_dots);
                    if (w_draw) begin
                        n_mode = E_DOTS;
                        n_cnt  = 5'd3;
                    end
                end else if (w_wc == W_TAB) begin
                    n_state = ST_DIV;
                end else begin
                    n_pen = clamp_pen(w_sum);
                    if (w_draw && w_glyph.n != '0) begin
                        n_mode = E_GLYPH;
                        n_cnt  = w_glyph.n;
                    end
                end
            end
            ST_DIV: begin
                if (w_div_done) begin
                    n_pen   = clamp_pen(w_tab);
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (w_free) begin
                    n_out_valid       = 1'b1;
                    n_out.text_width  = r_pen[16] ? 16'hFFFF : r_pen[15:0];
                    n_out.last        = w_last;
                    if (r_mode == E_REPORT) begin
                        n_out.x_from = '0;
                        n_out.y_from = '0;
                        n_out.x_to   = '0;
                        n_out.y_to   = '0;
                        n_out.kind   = KIND_NONE;
                    end else begin
                        n_out.x_from = w_x0;
                        n_out.y_from = w_y0;
                        n_out.x_to   = w_x1;
                        n_out.y_to   = w_y1;
                        n_out.kind   = w_sd.pt ? KIND_POINT : KIND_LINE;
                    end
                    n_dot_x = r_dot_x + 16'(w_step);
                    n_idx   = r_idx + 4'd1;
                    if (w_last) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_origin_x  <= '0;
            r_origin_y  <= '0;
            r_pen       <= '0;
            r_clipped   <= 1'b0;
            r_mode      <= E_REPORT;
            r_cnt       <= 5'd1;
            r_idx       <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_origin_x  <= n_origin_x;
            r_origin_y  <= n_origin_y;
            r_pen       <= n_pen;
            r_clipped   <= n_clipped;
            r_mode      <= n_mode;
            r_cnt       <= n_cnt;
            r_idx       <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ch    <= n_ch;
        r_gx    <= n_gx;
        r_dot_x <= n_dot_x;
        r_out   <= n_out;
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

`ifndef SYNTH
    // once clipped, only a new string clears the flag
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clipped && !(i_in_valid && o_in_ready && i_in.first_char) |=> r_clipped)
        else $error("clip flag dropped inside a string");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> r_state == ST_DIV)
        else $error("divider finished outside the tab wait");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_EMIT |-> 5'(r_idx) < r_cnt)
        else $error("stroke index past the stroke count");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_EMIT |=> $stable(r_pen))
        else $error("pen moved while strokes are sent");
`endif

endmodule

`default_nettype wire

/* tb/vector_stroke_font_generator_tb.sv */
// self-checking testbench of the vector stroke font generator with a stroke predictor
`timescale 1ns / 1ps

module vector_stroke_font_generator_tb;
    import vsf_pkg::*;

    class stroke_scoreboard;
        int    s1;
        int    clip_w;
        bit    measure;
        int    pen;
        int    org_x;
        int    org_y;
        bit    clipped;
        int    q1, q2, q3, q4, q5, q6, qr;
        t_out  strokes[$];
        t_out  pending_strokes[$];
        int    errors;

        function new();
            s1 = 2;
            clip_w = 65535;
            measure = 0;
            pen = 0;
            org_x = 0;
            org_y = 0;
            clipped = 0;
            errors = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [15:0] val);
            if (idx == CFG_GLYPH_SIZE) s1 = int'(val[5:0]);
            else if (idx == CFG_MAX_WIDTH) clip_w = int'(val);
            else if (idx == CFG_MEASURE) measure = val[0];
        endfunction

        function bit in_set(string s, logic [7:0] c);
            if (c == 0) return 0;
            for (int i = 0; i < s.len(); i++) if (s[i] == c) return 1;
            return 0;
        endfunction

        function void add(int x0, int y0, int x1, int y1, logic [1:0] k);
            t_out o;
            if (strokes.size() >= 16) return;
            o = '0;
            o.x_from = 16'(x0);
            o.y_from = 16'(y0);
            o.x_to = 16'(x1);
            o.y_to = 16'(y1);
            o.kind = k;
            strokes.push_back(o);
        endfunction

        function void ln(int x0, int y0, int x1, int y1);
            add(x0, y0, x1, y1, KIND_LINE);
        endfunction

        function void pt(int x, int y);
            add(x, y, x, y, KIND_POINT);
        endfunction

        function void arc_ul(int x, int y);
            ln(x - q1, y, x - qr, y - qr); ln(x - qr, y - qr, x, y - q1);
        endfunction
        function void arc_ur(int x, int y);
            ln(x + q1, y, x + qr, y - qr); ln(x + qr, y - qr, x, y - q1);
        endfunction
        function void arc_ll(int x, int y);
            ln(x - q1, y, x - qr, y + qr); ln(x - qr, y + qr, x, y + q1);
        endfunction
        function void arc_lr(int x, int y);
            ln(x + q1, y, x + qr, y + qr); ln(x + qr, y + qr, x, y + q1);
        endfunction
        function void arc_up(int x, int y); arc_ul(x, y); arc_ur(x, y); endfunction
        function void arc_lo(int x, int y); arc_ll(x, y); arc_lr(x, y); endfunction
        function void arc_rt(int x, int y); arc_ur(x, y); arc_lr(x, y); endfunction
        function void arc_lf(int x, int y); arc_ul(x, y); arc_ll(x, y); endfunction

        function void draw_glyph(logic [7:0] c, int a, int b, inout int gap_extra,
                                 inout int adv_adj);
            int h;
            h = q1 >> 1;
            if (in_set("abdgopq68", c)) begin
                arc_up(a + q1, b + q3); arc_lo(a + q1, b + q3);
            end else begin
                if (in_set("cehmnrs", c)) arc_ul(a + q1, b + q3);
                if (in_set("ehmnrBS35", c)) arc_ur(a + q1, b + q3);
                if (in_set("cetuyCGJOQSUl035", c)) arc_ll(a + q1, b + q3);
                if (in_set("suyBCDGJOQSU035", c)) arc_lr(a + q1, b + q3);
                if (in_set("BDEFHKLMNPR", c)) ln(a, b, a, b + q4);
            end
            case (c)
                "a": ln(a+q2, b+q2, a+q2, b+q4);
                "b": ln(a, b, a, b+q4);
                "c": begin ln(a+q1, b+q2, a+q2, b+q2); ln(a+q1, b+q4, a+q2, b+q4); end
                "d": ln(a+q2, b, a+q2, b+q4);
                "e": begin ln(a, b+q3, a+q2, b+q3); ln(a+q1, b+q4, a+q2, b+q4); end
                "f": begin
                    arc_ul(a+q1, b+q1); ln(a, b+q1, a, b+q4); ln(a, b+q2, a+q1, b+q2);
                end
                "g": begin ln(a+q2, b+q2, a+q2, b+q5); arc_lo(a+q1, b+q5); end
                "h": begin ln(a, b, a, b+q4); ln(a+q2, b+q3, a+q2, b+q4); end
                "i": begin pt(a, b+q1); ln(a, b+q2, a, b+q4); adv_adj -= q1 - 1; end
                "j": begin
                    ln(a+q1, b+q2, a+q1, b+q5); arc_lr(a, b+q5); pt(a+q1, b+q1);
                end
                "k": begin
                    ln(a, b, a, b+q4); ln(a, b+q3, a+q1, b+q2); ln(a, b+q3, a+q1, b+q4);
                end
                "l": ln(a, b, a, b+q3);
                "m": begin
                    ln(a, b+q2, a, b+q4); ln(a+q2, b+q3, a+q2, b+q4);
                    ln(a+q4, b+q3, a+q4, b+q4); arc_up(a+q3, b+q3);
                end
                "n": begin ln(a, b+q2, a, b+q4); ln(a+q2, b+q3, a+q2, b+q4); end
                "p": ln(a, b+q2, a, b+q6);
                "q": ln(a+q2, b+q2, a+q2, b+q6);
                "r": ln(a, b+q2, a, b+q4);
                "s": begin
                    ln(a, b+q3, a+q2, b+q3); ln(a+q1, b+q2, a+q2, b+q2);
                    ln(a, b+q4, a+q1, b+q4);
                end
                "t": begin ln(a, b+q1, a, b+q3); ln(a, b+q2, a+q1, b+q2); end
                "u": begin ln(a, b+q2, a, b+q3); ln(a+q2, b+q2, a+q2, b+q4); end
                "v": begin ln(a, b+q2, a+q1, b+q4); ln(a+q1, b+q4, a+q2, b+q2); end
                "w": begin
                    ln(a, b+q2, a+q1, b+q4); ln(a+q1, b+q4, a+q2, b+q3);
                    ln(a+q2, b+q3, a+q3, b+q4); ln(a+q3, b+q4, a+q4, b+q2);
                end
                "x": begin ln(a, b+q2, a+q2, b+q4); ln(a, b+q4, a+q2, b+q2); end
                "y": begin
                    ln(a, b+q2, a, b+q3); ln(a+q2, b+q2, a+q2, b+q5); arc_lo(a+q1, b+q5);
                end
                "z": begin
                    ln(a, b+q2, a+q2, b+q2); ln(a+q2, b+q2, a, b+q4);
                    ln(a, b+q4, a+q2, b+q4);
                end
                "A": begin
                    ln(a, b+q4, a+q1, b); ln(a+q1, b, a+q2, b+q4);
                    ln(a+h, b+q2, a+q2-h, b+q2);
                end
                "B": begin
                    arc_rt(a+q1, b+q1); ln(a, b, a+q1, b); ln(a, b+q2, a+q1, b+q2);
                    ln(a, b+q4, a+q1, b+q4);
                end
                "C": begin arc_up(a+q1, b+q1); ln(a, b+q1, a, b+q3); end
                "D": begin
                    ln(a, b, a+q1, b); ln(a, b+q4, a+q1, b+q4); arc_ur(a+q1, b+q1);
                    ln(a+q2, b+q1, a+q2, b+q3);
                end
                "E": begin
                    ln(a, b, a+q2, b); ln(a, b+q2, a+q1, b+q2); ln(a, b+q4, a+q2, b+q4);
                end
                "F": begin ln(a, b, a+q2, b); ln(a, b+q2, a+q1, b+q2); end
                "G": begin
                    arc_up(a+q1, b+q1); ln(a, b+q1, a, b+q3); ln(a+q1, b+q2, a+q2, b+q2);
                    ln(a+q2, b+q2, a+q2, b+q3);
                end
                "H": begin ln(a, b+q2, a+q2, b+q2); ln(a+q2, b, a+q2, b+q4); end
                "I": begin
                    ln(a, b, a+q2, b); ln(a+q1, b, a+q1, b+q4); ln(a, b+q4, a+q2, b+q4);
                end
                "J": ln(a+q2, b, a+q2, b+q3);
                "K": begin ln(a+q2, b, a, b+q2); ln(a, b+q2, a+q2, b+q4); end
                "L": ln(a, b+q4, a+q2, b+q4);
                "M": begin
                    ln(a, b, a+q1+h, b+q2); ln(a+q1+h, b+q2, a+q3, b);
                    ln(a+q3, b, a+q3, b+q4); adv_adj -= q1;
                end
                "N": begin ln(a, b, a+q2, b+q4); ln(a+q2, b+q4, a+q2, b); end
                "Q": begin
                    ln(a+q1, b+q3, a+q2, b+q4); gap_extra += 3;
                    arc_up(a+q1, b+q1); ln(a, b+q1, a, b+q3); ln(a+q2, b+q1, a+q2, b+q3);
                end
                "0": begin
                    gap_extra += 3;
                    arc_up(a+q1, b+q1); ln(a, b+q1, a, b+q3); ln(a+q2, b+q1, a+q2, b+q3);
                end
                "O": begin
                    arc_up(a+q1, b+q1); ln(a, b+q1, a, b+q3); ln(a+q2, b+q1, a+q2, b+q3);
                end
                "R": begin
                    ln(a+q1, b+q2, a+q2, b+q4); arc_rt(a+q1, b+q1); ln(a, b, a+q1, b);
                    ln(a, b+q2, a+q1, b+q2);
                end
                "P": begin
                    arc_rt(a+q1, b+q1); ln(a, b, a+q1, b); ln(a, b+q2, a+q1, b+q2);
                end
                "S": begin arc_lf(a+q1, b+q1); arc_ur(a+q1, b+q1); end
                "T": begin ln(a, b, a+q2, b); ln(a+q1, b, a+q1, b+q4); end
                "U": begin ln(a, b, a, b+q3); ln(a+q2, b, a+q2, b+q3); end
                "V": begin ln(a, b, a+q1, b+q4); ln(a+q1, b+q4, a+q2, b); end
                "W": begin
                    ln(a, b, a+q1, b+q4); ln(a+q1, b+q4, a+q2, b+q2);
                    ln(a+q2, b+q2, a+q3, b+q4); ln(a+q3, b+q4, a+q4, b);
                end
                "X": begin ln(a, b, a+q2, b+q4); ln(a+q2, b, a, b+q4); end
                "Y": begin
                    ln(a, b, a+q1, b+q2); ln(a+q2, b, a+q1, b+q2);
                    ln(a+q1, b+q2, a+q1, b+q4);
                end
                "Z": begin
                    ln(a, b, a+q2, b); ln(a+q2, b, a, b+q4); ln(a, b+q4, a+q2, b+q4);
                end
                "1": begin
                    ln(a, b+q1, a+q1, b); ln(a+q1, b, a+q1, b+q4);
                    ln(a, b+q4, a+q2, b+q4); gap_extra += 3;
                end
                "2": begin
                    arc_up(a+q1, b+q1); ln(a+q2, b+q1, a, b+q4);
                    ln(a, b+q4, a+q2, b+q4); gap_extra += 3;
                end
                "3": begin arc_up(a+q1, b+q1); arc_lr(a+q1, b+q1); gap_extra += 3; end
                "4": begin
                    ln(a+q1, b+q4, a+q1, b); ln(a+q1, b, a, b+q2);
                    ln(a, b+q2, a+q2, b+q2); gap_extra += 3;
                end
                "5": begin
                    ln(a+q2, b, a, b); ln(a, b, a, b+q2); ln(a, b+q2, a+q1, b+q2);
                    gap_extra += 3;
                end
                "6": begin arc_up(a+q1, b+q1); ln(a, b+q1, a, b+q3); gap_extra += 3; end
                "7": begin ln(a, b, a+q2, b); ln(a+q2, b, a+q1, b+q4); gap_extra += 3; end
                "9": begin
                    ln(a+q2, b, a+q2, b+q4); arc_up(a+q1, b+q1); arc_lo(a+q1, b+q1);
                    gap_extra += 3;
                end
                "8": begin arc_up(a+q1, b+q1); arc_lo(a+q1, b+q1); gap_extra += 3; end
                "-": ln(a, b+q2, a+q1, b+q2);
                ".": begin pt(a, b+q4); adv_adj -= q1 - 1; end
                "(": begin
                    arc_ul(a+q1, b+q1); arc_ll(a+q1, b+q3); ln(a, b+q1, a, b+q3);
                end
                ")": begin
                    arc_ur(a, b+q1); arc_lr(a, b+q3); ln(a+q1, b+q1, a+q1, b+q3);
                end
                "%": begin pt(a, b); pt(a+q2, b+q4); ln(a, b+q4, a+q2, b); end
                "/": ln(a, b+q4, a+q2, b);
                "?": begin
                    arc_up(a+q1, b+q1); ln(a+q2, b+q1, a+q1, b+q2);
                    ln(a+q1, b+q2, a+q1, b+q3); pt(a+q1, b+q4);
                end
                default: ;
            endcase
        endfunction

        function void note_input(t_in t);
            int gap;
            int gap_extra;
            int adv_adj;
            int gx;
            int a;
            int tw;
            logic [7:0] c;
            c = t.ch;
            gap_extra = 0;
            adv_adj = 0;
            strokes.delete();
            if (t.first_char) begin
                org_x = t.start_x;
                org_y = t.start_y;
                pen = 0;
                clipped = 0;
            end
            q1 = s1; q2 = 2 * s1; q3 = 3 * s1; q4 = 4 * s1; q5 = 5 * s1; q6 = 6 * s1;
            qr = (3 * s1) >> 2;
            gap = (q1 != 0) ? q1 : 1;
            gx = org_x + pen;
            a = gx;
            if (!clipped) begin
                if (clip_w != 65535 && pen > clip_w - q3 - q4) begin
                    // three dots instead of the character
                    for (int i = 0; i < 3; i++) begin
                        if (!measure) begin
                            pt(a, org_y + q4);
                            a += 1 + gap;
                        end else begin
                            a += q1 + gap;
                        end
                    end
                    clipped = 1;
                end else begin
                    if (!measure) draw_glyph(c, gx, org_y, gap_extra, adv_adj);
                    if (in_set("ltfijk-. ()", c)) a += q1;
                    else if (in_set({"?/%abcdeghnopqrsuvxyzABCDEFGHIJKLNOPQRSTUVXYZ",
                                     "0123456789"}, c)) a += q2;
                    else if (in_set("mwMW", c)) a += q4;
                    else if (c == CH_TAB) a = (a / 64 + 1) * 64;
                    else begin
                        if (!measure) ln(gx, org_y + q4, gx + q2, org_y + q4);
                        a += q2;
                    end
                    a += adv_adj + gap + gap_extra;
                end
                a -= org_x;
                if (a < 0) a = 0;
                if (a > 131071) a = 131071;
                pen = a;
            end
            if (strokes.size() == 0) add(0, 0, 0, 0, KIND_NONE);
            tw = (pen > 65535) ? 65535 : pen;
            foreach (strokes[i]) begin
                strokes[i].text_width = 16'(tw);
                strokes[i].last = (i == strokes.size() - 1);
                pending_strokes.push_back(strokes[i]);
            end
        endfunction

        function void check_result(t_out r);
            t_out e;
            if (pending_strokes.size() == 0) begin
                $display("%0t: unexpected stroke %p", $realtime, r);
                errors++;
                return;
            end
            e = pending_strokes.pop_front();
            if (r.x_from !== e.x_from) begin
                $display("%0t: x_from exp %0d got %0d", $realtime, e.x_from, r.x_from);
                errors++;
            end
            if (r.y_from !== e.y_from) begin
                $display("%0t: y_from exp %0d got %0d", $realtime, e.y_from, r.y_from);
                errors++;
            end
            if (r.x_to !== e.x_to) begin
                $display("%0t: x_to exp %0d got %0d", $realtime, e.x_to, r.x_to);
                errors++;
            end
            if (r.y_to !== e.y_to) begin
                $display("%0t: y_to exp %0d got %0d", $realtime, e.y_to, r.y_to);
                errors++;
            end
            if (r.kind !== e.kind) begin
                $display("%0t: kind exp %0d got %0d", $realtime, e.kind, r.kind);
                errors++;
            end
            if (r.text_width !== e.text_width) begin
                $display("%0t: text_width exp %0d got %0d", $realtime, e.text_width,
                         r.text_width);
                errors++;
            end
            if (r.last !== e.last) begin
                $display("%0t: last exp %0d got %0d", $realtime, e.last, r.last);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_idx;
    logic [15:0] i_cfg_data;
    logic        i_in_valid;
    logic        o_in_ready;
    t_in         i_in;
    logic        o_out_valid;
    logic        i_out_ready;
    t_out        o_out;

    stroke_scoreboard sb;
    bit          no_idle;
    bit          hold_req;
    int          idle_cycles = 0;

    vector_stroke_font_generator dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

    always begin
        i_clk = 1'b1; #5;
        i_clk = 1'b0; #5;
    end

    // receiver: per-transaction stall, plus one long hold on request
    always @(posedge i_clk) begin : receiver
        static int wait_cnt = 0;
        static int long_hold = 0;
        static bit hold_taken = 0;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            sb.check_result(o_out);
            wait_cnt = no_idle ? 0 : $urandom_range(0, 13);
        end
        if (hold_req && !hold_taken) begin
            hold_taken = 1;
            long_hold = 400;
        end
        if (long_hold > 0) begin
            long_hold--;
            i_out_ready <= 1'b0;
        end else if (wait_cnt > 0) begin
            wait_cnt--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) || !i_rst_n)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= 3000) begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic write_reg(logic [1:0] idx, logic [15:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        sb.set_reg(idx, val);
        @(posedge i_clk);
    endtask

    task automatic send_char(logic [7:0] c, logic signed [15:0] x, logic signed [15:0] y,
                             bit first, bit eos);
        t_in t;
        int gap;
        t.ch = c;
        t.start_x = x;
        t.start_y = y;
        t.first_char = first;
        t.end_of_string = eos;
        gap = no_idle ? 0 : $urandom_range(0, 13);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in       <= t;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_input(t);
    endtask

    // sender pauses until every stroke is back, then lets the block settle
    task automatic drain();
        i_in_valid <= 1'b0;
        while (sb.pending_strokes.size() != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
    endtask

    task automatic send_string(int len);
        string font_chars;
        logic [7:0] c;
        logic signed [15:0] x;
        logic signed [15:0] y;
        int r;
        font_chars = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789-.()%/?";
        x = 16'($urandom);
        y = 16'($urandom);
        case ($urandom_range(0, 5))
            0: x = 16'sh8000;
            1: x = 16'sh7FFF;
            2: y = 16'sh8000;
            3: y = 16'sh7FFF;
            default: ;
        endcase
        for (int i = 0; i < len; i++) begin
            r = $urandom_range(0, 99);
            if (r < 70) c = font_chars[$urandom_range(0, font_chars.len() - 1)];
            else if (r < 78) c = CH_TAB;
            else if (r < 86) c = " ";
            else c = 8'($urandom_range(0, 255));
            // mostly well-formed strings, sometimes a stray origin in the middle
            send_char(c, (i == 0 || $urandom_range(0, 19) == 0) ? x : 16'($urandom),
                      (i == 0) ? y : 16'($urandom),
                      i == 0 || $urandom_range(0, 29) == 0, i == len - 1);
        end
    endtask

    initial begin
        int sizes[8];
        int clips[8];
        sb = new();
        no_idle = 0;
        hold_req = 0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = CFG_GLYPH_SIZE;
        i_cfg_data = '0;
        i_in_valid = 1'b0;
        i_in = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset settings, densest glyphs, narrow glyphs, tab, unknown codes
        send_char("8", -16'sd5, 16'sd10, 1, 0);
        send_char("Q", 0, 0, 0, 0);
        send_char("i", 0, 0, 0, 0);
        send_char(".", 0, 0, 0, 0);
        send_char("M", 0, 0, 0, 0);
        send_char(CH_TAB, 0, 0, 0, 0);
        send_char(8'd0, 0, 0, 0, 0);
        send_char(8'd255, 0, 0, 0, 0);
        send_char(8'd128, 0, 0, 0, 0);
        send_char(" ", 0, 0, 0, 1);
        send_char("%", 16'sh8000, 16'sh7FFF, 1, 0);
        send_char("?", 0, 0, 0, 0);
        send_char("j", 0, 0, 0, 0);
        send_char(CH_TAB, 0, 0, 0, 1);
        send_char(CH_TAB, 16'sh7FFF, 16'sh8000, 1, 1);
        send_char("9", -16'sd100, 0, 1, 1);
        drain();
        write_reg(CFG_GLYPH_SIZE, 16'd63);
        write_reg(CFG_MAX_WIDTH, 16'd600);
        write_reg(CFG_MEASURE, 16'd0);
        send_char("W", 16'sh7F00, 16'sh7FF0, 1, 0);
        send_char("8", 0, 0, 0, 0);
        send_char("m", 0, 0, 0, 0);
        send_char("0", 0, 0, 0, 0);
        send_char("a", 0, 0, 0, 1);
        drain();

        sizes = '{0, 63, 1, 5, 63, 3, 2, 17};
        clips = '{65535, 65535, 30, 200, 0, 120, 65535, 900};
        for (int p = 0; p < 8; p++) begin
            write_reg(CFG_GLYPH_SIZE, 16'(sizes[p]));
            write_reg(CFG_MAX_WIDTH, 16'(clips[p]));
            write_reg(CFG_MEASURE, 16'((p % 3 == 2) ? 1 : 0));
            no_idle = (p == 4);
            if (p == 1) hold_req = 1;
            for (int n = 0; n < 36; ) begin
                int len;
                len = $urandom_range(1, 12);
                send_string(len);
                n += len;
            end
            drain();
        end
        write_reg(CFG_GLYPH_SIZE, 16'($urandom_range(0, 63)));
        write_reg(CFG_MAX_WIDTH, 16'($urandom_range(0, 65535)));
        write_reg(CFG_MEASURE, 16'($urandom_range(0, 1)));
        send_string(12);
        drain();

        if (sb.errors == 0 && sb.pending_strokes.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

/* filelist.f */
src/vsf_pkg.sv
src/vsf_coord_unit.sv
src/vsf_tab_div.sv
src/vector_stroke_font_generator.sv
tb/vector_stroke_font_generator_tb.sv
